// ===== hw/rtl/uvsig_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere index generator package
// Shared types and constants for the triangle index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvsig_pkg;

	localparam int MAX_SLICES = 255;
	localparam int MAX_STACKS = 255;

	localparam int CNT_W = 8;
	localparam int IDX_W = 16;

	localparam int REM_CNT_W = 4;
	localparam int REM_STEPS = CNT_W + 1;

	localparam logic [CNT_W-1:0] MIN_SLICES = CNT_W'(3);
	localparam logic [CNT_W-1:0] MIN_STACKS = CNT_W'(2);
	localparam logic [CNT_W-1:0] RESET_SLICES = CNT_W'(8);
	localparam logic [CNT_W-1:0] RESET_STACKS = CNT_W'(8);

	localparam logic [0:0] REG_SLICE_COUNT = 1'b0;
	localparam logic [0:0] REG_STACK_COUNT = 1'b1;

	localparam logic [1:0] PH_TOP = 2'd0;
	localparam logic [1:0] PH_INNER = 2'd1;
	localparam logic [1:0] PH_BOTTOM = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic [IDX_W-1:0] third_index;
		logic last_triangle;
	} tri_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uvsig_core.sv =====
// ----------------------------------------------------------------------------
// UV sphere index generator core
// Walk state registers and the combinational triangle index computation.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsig_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire logic restart,
	input wire logic refresh,
	input wire logic [uvsig_pkg::CNT_W-1:0] slices,
	input wire logic [uvsig_pkg::CNT_W-1:0] stacks,
	output logic busy,
	output uvsig_pkg::tri_t res
);
	import uvsig_pkg::*;

	logic [1:0] phase_q;
	logic [CNT_W-1:0] ring_cnt_q;
	logic [CNT_W-1:0] slice_cnt_q;
	logic second_half_q;
	logic [IDX_W-1:0] row_base_q;

	logic [1:0] phase_c;
	logic [CNT_W-1:0] ring_cnt_c;
	logic [CNT_W-1:0] slice_cnt_c;
	logic second_half_c;
	logic [IDX_W-1:0] row_base_c;

	logic [1:0] phase_n;
	logic [CNT_W-1:0] ring_cnt_n;
	logic [CNT_W-1:0] slice_cnt_n;
	logic second_half_n;
	logic [IDX_W-1:0] row_base_n;

	logic [CNT_W:0] s_nxt;
	logic [CNT_W-1:0] top_rem;
	logic [CNT_W:0] ring;
	logic [IDX_W-1:0] ring16;
	logic [CNT_W-1:0] inner_rows;
	logic [2*CNT_W:0] cap_prod;
	logic [IDX_W-1:0] cap_base;
	logic [IDX_W-1:0] up_j;
	logic [IDX_W-1:0] dn_j;
	logic [CNT_W:0] ring_nxt;

	logic rem_busy_q;
	logic [REM_CNT_W-1:0] rem_cnt_q;
	logic [CNT_W:0] rem_num_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0] rem_try;

	// After a count change the stored slice position may lie beyond the new
	// slice count, so its remainder is rebuilt one bit per cycle.
	assign rem_try = {rem_q, rem_num_q[CNT_W]};
	assign busy = rem_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_busy_q <= 1'b0;
			rem_cnt_q <= '0;
			rem_num_q <= '0;
			rem_q <= '0;
		end else if (refresh) begin
			rem_busy_q <= 1'b1;
			rem_cnt_q <= REM_CNT_W'(REM_STEPS);
			rem_num_q <= {1'b0, slice_cnt_q} + (CNT_W+1)'(1);
			rem_q <= '0;
		end else if (rem_busy_q) begin
			if (rem_try >= {1'b0, slices}) begin
				rem_q <= CNT_W'(rem_try - {1'b0, slices});
			end else begin
				rem_q <= rem_try[CNT_W-1:0];
			end
			rem_num_q <= {rem_num_q[CNT_W-1:0], 1'b0};
			rem_cnt_q <= rem_cnt_q - REM_CNT_W'(1);
			if (rem_cnt_q == REM_CNT_W'(1)) begin
				rem_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (restart || phase_q == PH_UNUSED) begin
			phase_c = PH_TOP;
			ring_cnt_c = '0;
			slice_cnt_c = '0;
			second_half_c = 1'b0;
			row_base_c = IDX_W'(1);
		end else begin
			phase_c = phase_q;
			ring_cnt_c = ring_cnt_q;
			slice_cnt_c = slice_cnt_q;
			second_half_c = second_half_q;
			row_base_c = row_base_q;
		end
	end

	assign ring = {1'b0, slices} + (CNT_W+1)'(1);
	assign ring16 = IDX_W'(ring);
	assign inner_rows = stacks - MIN_STACKS;
	assign s_nxt = {1'b0, slice_cnt_c} + (CNT_W+1)'(1);
	assign top_rem = (s_nxt < {1'b0, slices}) ? s_nxt[CNT_W-1:0]
		: (s_nxt == {1'b0, slices}) ? '0 : rem_q;
	assign cap_prod = inner_rows * ring;
	assign cap_base = cap_prod[IDX_W-1:0] + IDX_W'(1);
	assign up_j = row_base_c + IDX_W'(slice_cnt_c);
	assign dn_j = up_j + ring16;
	assign ring_nxt = {1'b0, ring_cnt_c} + (CNT_W+1)'(1);

	always_comb begin
		phase_n = phase_c;
		ring_cnt_n = ring_cnt_c;
		slice_cnt_n = slice_cnt_c;
		second_half_n = second_half_c;
		row_base_n = row_base_c;
		res = '0;
		case (phase_c)
			PH_TOP: begin
				res.first_index = '0;
				res.second_index = IDX_W'(top_rem) + IDX_W'(1);
				res.third_index = IDX_W'(s_nxt);
				if (s_nxt >= {1'b0, slices}) begin
					slice_cnt_n = '0;
					ring_cnt_n = '0;
					second_half_n = 1'b0;
					row_base_n = IDX_W'(1);
					phase_n = (stacks > MIN_STACKS) ? PH_INNER : PH_BOTTOM;
				end else begin
					slice_cnt_n = s_nxt[CNT_W-1:0];
				end
			end
			PH_INNER: begin
				if (!second_half_c) begin
					res.first_index = up_j;
					res.second_index = up_j + IDX_W'(1);
					res.third_index = dn_j;
					second_half_n = 1'b1;
				end else begin
					res.first_index = dn_j;
					res.second_index = up_j + IDX_W'(1);
					res.third_index = dn_j + IDX_W'(1);
					second_half_n = 1'b0;
					if (s_nxt >= {1'b0, slices}) begin
						slice_cnt_n = '0;
						row_base_n = row_base_c + ring16;
						if (ring_nxt >= {1'b0, inner_rows}) begin
							ring_cnt_n = '0;
							phase_n = PH_BOTTOM;
						end else begin
							ring_cnt_n = ring_nxt[CNT_W-1:0];
						end
					end else begin
						slice_cnt_n = s_nxt[CNT_W-1:0];
					end
				end
			end
			default: begin
				res.first_index = cap_base + ring16;
				res.second_index = cap_base + IDX_W'(slice_cnt_c);
				if (s_nxt >= {1'b0, slices}) begin
					res.third_index = cap_base;
					res.last_triangle = 1'b1;
					phase_n = PH_TOP;
					ring_cnt_n = '0;
					slice_cnt_n = '0;
					second_half_n = 1'b0;
					row_base_n = IDX_W'(1);
				end else begin
					res.third_index = cap_base + IDX_W'(s_nxt);
					slice_cnt_n = s_nxt[CNT_W-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOP;
			ring_cnt_q <= '0;
			slice_cnt_q <= '0;
			second_half_q <= 1'b0;
			row_base_q <= IDX_W'(1);
		end else if (take) begin
			phase_q <= phase_n;
			ring_cnt_q <= ring_cnt_n;
			slice_cnt_q <= slice_cnt_n;
			second_half_q <= second_half_n;
			row_base_q <= row_base_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_unused_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_UNUSED)
		else $error("walk reached the unused phase code");

	a_restart_top: assert property (@(posedge clk) disable iff (!arst_n)
		take && restart |=> phase_q == PH_TOP && slice_cnt_q == CNT_W'(1)
		&& row_base_q == IDX_W'(1))
		else $error("restart did not resume inside the top cap");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.last_triangle |=> phase_q == PH_TOP && slice_cnt_q == '0
		&& ring_cnt_q == '0 && !second_half_q)
		else $error("final triangle did not wrap the walk to the start");

	a_half_only_inner: assert property (@(posedge clk) disable iff (!arst_n)
		second_half_q |-> phase_q == PH_INNER)
		else $error("second half flag set outside the inner stacks");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/uvsig_out_buf.sv =====
// ----------------------------------------------------------------------------
// UV sphere index generator output buffer
// Two-entry result register with a skid entry so requests keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module uvsig_out_buf (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire uvsig_pkg::tri_t push_data,
	output logic full,
	output logic out_valid,
	input wire logic out_stall,
	output uvsig_pkg::tri_t out_data
);
	import uvsig_pkg::*;

	logic main_vld_q;
	logic skid_vld_q;
	tri_t main_q;
	tri_t skid_q;
	logic pop;

	assign pop = main_vld_q && !out_stall;
	assign full = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (!main_vld_q) begin
			main_vld_q <= push;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (!main_vld_q) begin
			if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry held without a main entry");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("request pushed into a full output buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && pop |=> !skid_vld_q && main_vld_q)
		else $error("skid entry not moved into the main entry");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/uv_sphere_index_generator.sv =====
// An accepted request's triangle is registered in the output buffer's main entry, or in its skid entry if held.
// Throughput: one triangle per cycle while in_stall is low; the walk counters update on each accepted request.
// A two-entry output buffer lets requests continue under out_stall until both entries are full.
// Each configuration write stalls requests while it is asserted and while the core rebuilds the slice remainder.
// Reset clears the walk to the first top-cap triangle and sets both counts to 8.
// ----------------------------------------------------------------------------
// UV sphere index generator
// Emits the triangle index list of a latitude/longitude sphere, one triangle per request.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_index_generator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [uvsig_pkg::CNT_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic restart,
	output logic out_valid,
	input wire logic out_stall,
	output logic [uvsig_pkg::IDX_W-1:0] first_index,
	output logic [uvsig_pkg::IDX_W-1:0] second_index,
	output logic [uvsig_pkg::IDX_W-1:0] third_index,
	output logic last_triangle
);
	import uvsig_pkg::*;

	logic [CNT_W-1:0] slice_cfg_q;
	logic [CNT_W-1:0] stack_cfg_q;
	logic [CNT_W-1:0] slices;
	logic [CNT_W-1:0] stacks;
	logic take;
	logic full;
	logic busy;
	tri_t res;
	tri_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_cfg_q <= RESET_SLICES;
			stack_cfg_q <= RESET_STACKS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLICE_COUNT: slice_cfg_q <= cfg_data;
				REG_STACK_COUNT: stack_cfg_q <= cfg_data;
				default: slice_cfg_q <= slice_cfg_q;
			endcase
		end
	end

	always_comb begin
		slices = slice_cfg_q;
		if (slices < MIN_SLICES) begin
			slices = MIN_SLICES;
		end else if (32'(slices) > MAX_SLICES) begin
			slices = CNT_W'(MAX_SLICES);
		end
		stacks = stack_cfg_q;
		if (stacks < MIN_STACKS) begin
			stacks = MIN_STACKS;
		end else if (32'(stacks) > MAX_STACKS) begin
			stacks = CNT_W'(MAX_STACKS);
		end
	end

	assign in_stall = full || busy || cfg_we;
	assign take = in_valid && !in_stall;

	uvsig_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.restart(restart),
		.refresh(cfg_we),
		.slices(slices),
		.stacks(stacks),
		.busy(busy),
		.res(res)
	);

	uvsig_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(take),
		.push_data(res),
		.full(full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	assign first_index = out_data.first_index;
	assign second_index = out_data.second_index;
	assign third_index = out_data.third_index;
	assign last_triangle = out_data.last_triangle;

endmodule

`default_nettype wire
